// ===== rtl/core/pool_slot_allocator_macros.svh =====
// Assertion macros shared by the pool slot allocator RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef POOL_SLOT_ALLOCATOR_MACROS_SVH
`define POOL_SLOT_ALLOCATOR_MACROS_SVH

// check an overlapping implication on every clock edge out of reset
`define PSA_ASSERT_IMPL(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// check a next-cycle implication on every clock edge out of reset
`define PSA_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/core/psa_pkg.sv =====
// Shared types and constants of the pool slot allocator.
// No dependencies.
package psa_pkg;

	localparam int unsigned POOL_SLOTS_DEF = 1024;
	localparam int unsigned SLOT_W         = 10;
	localparam int unsigned REG_W          = 11;
	localparam int unsigned DATA_W         = 16;
	localparam int unsigned CFG_INDEX_W    = 8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SLOTS = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 8'd1;

	localparam logic [REG_W-1:0] BLOCK_SLOTS_RST = 11'd64;
	localparam logic [REG_W-1:0] BLOCK_COUNT_RST = 11'd16;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_POP  = 3'b100
	} state_t;

endpackage

// ===== rtl/core/psa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psa_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/psa_cfg.sv =====
// Configuration registers and bump capacity check of the pool slot allocator.
// Depends on psa_pkg.
module psa_cfg #(
	parameter int unsigned POOL_SLOTS = psa_pkg::POOL_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [psa_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [psa_pkg::REG_W-1:0]        cfg_data,
	input  logic [psa_pkg::REG_W-1:0]        bump_count,
	output logic                             bump_ok
);

	localparam int unsigned PROD_W = 2 * psa_pkg::REG_W;

	logic [psa_pkg::REG_W-1:0] block_slots_q;
	logic [psa_pkg::REG_W-1:0] block_count_q;
	logic [PROD_W-1:0]         capacity;
	logic                      below_pool;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_slots_q <= psa_pkg::BLOCK_SLOTS_RST;
			block_count_q <= psa_pkg::BLOCK_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == psa_pkg::REG_BLOCK_SLOTS) begin
				block_slots_q <= cfg_data;
			end
			if (cfg_index == psa_pkg::REG_BLOCK_COUNT) begin
				block_count_q <= cfg_data;
			end
		end
	end

	assign capacity   = PROD_W'(block_slots_q) * PROD_W'(block_count_q);
	assign below_pool = 32'(bump_count) < 32'(POOL_SLOTS);
	assign bump_ok    = (PROD_W'(bump_count) < capacity) && below_pool;

endmodule

// ===== rtl/core/pool_slot_allocator.sv =====
// Pool slot allocator top level: request sequencer, free-list link RAM, result register.
// Depends on psa_pkg, psa_ram, psa_cfg and pool_slot_allocator_macros.svh.
//
// Each request yields one result. A free or a bump allocation goes through the EXEC
// state into the result register; an allocation that pops the free list also goes
// through the POP state for the registered read of the successor from the link RAM.
// One request is in flight at a time; a finished result waits in the output register
// while the next request is accepted. The link RAM needs no clearing pass after reset.
`include "pool_slot_allocator_macros.svh"

module pool_slot_allocator #(
	parameter int unsigned POOL_SLOTS = psa_pkg::POOL_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [psa_pkg::DATA_W-1:0]       s_tdata,  // [9:0] free_slot
	input  logic                             s_tuser,  // [0] operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [psa_pkg::DATA_W-1:0]       m_tdata,  // [9:0] slot
	output logic                             m_tuser,  // [0] ok
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [psa_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [psa_pkg::REG_W-1:0]        cfg_data
);

	localparam int unsigned SW = psa_pkg::SLOT_W;
	localparam int unsigned AW = $clog2(POOL_SLOTS);

	psa_pkg::state_t state_q;

	logic          op_s1;
	logic [SW-1:0] slot_s1;
	logic [SW-1:0] free_slot_red;

	logic [SW-1:0]              head_q;
	logic                       nonempty_q;
	logic [psa_pkg::REG_W-1:0]  bump_count_q;
	logic                       bump_ok;

	logic          out_valid_q;
	logic [SW-1:0] out_slot_q;
	logic          out_ok_q;

	logic          accept;
	logic          commit;
	logic          pop_done;
	logic          exec_done;
	logic          free_done;
	logic          ram_we;
	logic          ram_re;
	logic [SW-1:0] ram_rdata;

	assign s_tready = (state_q == psa_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = !out_valid_q || m_tready;

	assign pop_done  = (state_q == psa_pkg::ST_POP) && commit;
	assign exec_done = (state_q == psa_pkg::ST_EXEC) && commit
		&& !(op_s1 == psa_pkg::OP_ALLOC && nonempty_q);
	assign free_done = exec_done && (op_s1 == psa_pkg::OP_FREE);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= s_tuser;
			slot_s1 <= s_tdata[SW-1:0];
		end
	end

	// reduce the freed slot modulo the pool size
	if (POOL_SLOTS >= (1 << SW)) begin : g_red_none
		assign free_slot_red = slot_s1;
	end else begin : g_red_recip
		localparam int unsigned RECIP_SHIFT = 2 * SW;
		localparam int unsigned RECIP = ((1 << RECIP_SHIFT) + POOL_SLOTS - 1) / POOL_SLOTS;
		logic [3*SW-1:0] recip_prod;
		logic [SW-1:0]   quot_s1;
		logic [2*SW-1:0] back_prod;

		assign recip_prod = (3 * SW)'(s_tdata[SW-1:0]) * (3 * SW)'(RECIP);

		always_ff @(posedge clk) begin
			if (accept) begin
				quot_s1 <= recip_prod[3*SW-1:RECIP_SHIFT];
			end
		end

		assign back_prod     = (2 * SW)'(quot_s1) * (2 * SW)'(POOL_SLOTS);
		assign free_slot_red = slot_s1 - back_prod[SW-1:0];
	end

	assign ram_we = (state_q == psa_pkg::ST_EXEC) && (op_s1 == psa_pkg::OP_FREE) && commit;
	assign ram_re = (state_q == psa_pkg::ST_EXEC) && (op_s1 == psa_pkg::OP_ALLOC) && nonempty_q;

	psa_ram #(
		.WIDTH (SW),
		.DEPTH (POOL_SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(free_slot_red)),
		.wdata (nonempty_q ? head_q : free_slot_red),
		.re    (ram_re),
		.raddr (AW'(head_q)),
		.rdata (ram_rdata)
	);

	psa_cfg #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.bump_count (bump_count_q),
		.bump_ok    (bump_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= psa_pkg::ST_IDLE;
			head_q       <= '0;
			nonempty_q   <= 1'b0;
			bump_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop_done || exec_done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				psa_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= psa_pkg::ST_EXEC;
					end
				end
				psa_pkg::ST_EXEC: begin
					if (op_s1 == psa_pkg::OP_ALLOC && nonempty_q) begin
						state_q <= psa_pkg::ST_POP;
					end else if (commit) begin
						state_q <= psa_pkg::ST_IDLE;
						if (op_s1 == psa_pkg::OP_FREE) begin
							head_q     <= free_slot_red;
							nonempty_q <= 1'b1;
						end else if (bump_ok) begin
							bump_count_q <= bump_count_q + 1'b1;
						end
					end
				end
				psa_pkg::ST_POP: begin
					if (commit) begin
						state_q <= psa_pkg::ST_IDLE;
						if (ram_rdata == head_q) begin
							nonempty_q <= 1'b0;
						end else begin
							head_q <= ram_rdata;
						end
					end
				end
				default: begin
					state_q <= psa_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_done) begin
			out_slot_q <= head_q;
			out_ok_q   <= 1'b1;
		end else if (exec_done) begin
			if (op_s1 == psa_pkg::OP_FREE) begin
				out_slot_q <= '0;
				out_ok_q   <= 1'b1;
			end else if (bump_ok) begin
				out_slot_q <= bump_count_q[SW-1:0];
				out_ok_q   <= 1'b1;
			end else begin
				out_slot_q <= '0;
				out_ok_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = psa_pkg::DATA_W'(out_slot_q);
	assign m_tuser  = out_ok_q;

	`PSA_ASSERT_NEXT(a_accept_exec, accept, state_q == psa_pkg::ST_EXEC, "request not executed")
	`PSA_ASSERT_IMPL(a_pop_nonempty, state_q == psa_pkg::ST_POP, nonempty_q, "pop on empty list")
	`PSA_ASSERT_NEXT(a_pop_ok, pop_done, m_tvalid && m_tuser, "pop failed")
	`PSA_ASSERT_NEXT(a_free_ok, free_done, m_tvalid && m_tuser && m_tdata == '0, "bad free result")

endmodule
